[sv/fbf_pkg.sv]
// Shared types, constants and helpers for the flow-controlled byte FIFO.
package fbf_pkg;

    localparam int DEPTH       = 32;
    localparam int AW          = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 32;

    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int FCNT_W  = 6;
    localparam int TOT_W   = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FCNT_W-1:0] CAP_RESET = 6'd32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 3'd0,
        ACT_END   = 3'd1,
        ACT_PEEK  = 3'd2,
        ACT_POP   = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    typedef struct packed {
        logic take;
        logic issue;
        logic move;
        logic drain;
    } t_dp_cmd;

    typedef struct packed {
        logic multi;
        logic issue_left;
        logic last_deliver;
        logic rd_pend;
        logic out_busy;
    } t_dp_stat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic              accepted;
        logic [FCNT_W-1:0] occupancy;
        logic [FCNT_W-1:0] room_left;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              ended;
        logic              at_eof;
    } t_result;

    // Ring slot at base plus offset, offset at most DEPTH.
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

endpackage

[sv/fbf_in_if.sv]
// Request channel: one action with its byte and count per transaction.
interface fbf_in_if;
    logic                         valid;
    logic                         ready;
    logic [fbf_pkg::ACT_W-1:0]    action;
    logic [fbf_pkg::BYTE_W-1:0]   in_byte;
    logic [fbf_pkg::FCNT_W-1:0]   req_count;

    modport source (output valid, action, in_byte, req_count, input ready);
    modport sink   (input valid, action, in_byte, req_count, output ready);
endinterface

[sv/fbf_out_if.sv]
// Result channel: one delivered byte or status word per transaction.
interface fbf_out_if;
    logic                         valid;
    logic                         ready;
    logic [fbf_pkg::BYTE_W-1:0]   out_byte;
    logic                         byte_valid;
    logic                         last;
    logic                         accepted;
    logic [fbf_pkg::FCNT_W-1:0]   occupancy;
    logic [fbf_pkg::FCNT_W-1:0]   room_left;
    logic [fbf_pkg::TOT_W-1:0]    total_written;
    logic [fbf_pkg::TOT_W-1:0]    total_read;
    logic                         ended;
    logic                         at_eof;

    modport source (output valid, out_byte, byte_valid, last, accepted, occupancy,
                    room_left, total_written, total_read, ended, at_eof, input ready);
    modport sink   (input valid, out_byte, byte_valid, last, accepted, occupancy,
                    room_left, total_written, total_read, ended, at_eof, output ready);
endinterface

[sv/fbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/fbf_ctrl.sv]
// Controller: sequences item acceptance and byte streaming for the datapath.
module fbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    input  fbf_pkg::t_dp_stat i_stat,
    output fbf_pkg::t_dp_cmd  o_cmd
);
    import fbf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        out_free    = !i_stat.out_busy || i_out_ready;
        o_cmd.drain = i_stat.out_busy && i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                o_cmd.take = i_in_valid && out_free;
                if (o_cmd.take && i_stat.multi) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                // move the fetched byte out, and refetch in the same cycle
                o_cmd.move  = i_stat.rd_pend && out_free;
                o_cmd.issue = i_stat.issue_left && (!i_stat.rd_pend || o_cmd.move);
                if (o_cmd.move && i_stat.last_deliver) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

[sv/fbf_dp.sv]
// Datapath: byte store, pointers, totals, stream counters and result register.
module fbf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fbf_pkg::ACT_W-1:0]   i_action,
    input  logic [fbf_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic [fbf_pkg::FCNT_W-1:0]  i_req_count,
    input  logic [fbf_pkg::FCNT_W-1:0]  i_capacity,
    input  fbf_pkg::t_dp_cmd            i_cmd,
    output fbf_pkg::t_dp_stat           o_stat,
    output logic                        o_res_valid,
    output fbf_pkg::t_result            o_res
);
    import fbf_pkg::*;

    t_action           act;
    logic [AW-1:0]     r_head,    n_head;
    logic [CNT_W-1:0]  r_fill,    n_fill;
    logic [TOT_W-1:0]  r_written, n_written;
    logic [TOT_W-1:0]  r_read,    n_read;
    logic              r_ended,   n_ended;
    logic [AW-1:0]     r_rd_addr;
    logic [CNT_W-1:0]  r_left_issue;
    logic [CNT_W-1:0]  r_left_deliver;
    logic              r_rd_pend;
    logic              r_res_valid;
    t_result           r_res;
    t_result           n_res;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  run_len;
    logic [CNT_W-1:0]  room;
    logic              can_write;
    logic              wr_ok;
    logic              multi;
    logic [BYTE_W-1:0] ram_rdata;

    assign act = t_action'(i_action);

    always_comb begin
        if (32'(i_capacity) > DEPTH) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(i_capacity);
        end
        if (32'(i_req_count) < 32'(r_fill)) begin
            run_len = CNT_W'(i_req_count);
        end else begin
            run_len = r_fill;
        end
        if (32'(run_len) > MAX_RESULTS) begin
            run_len = CNT_W'(MAX_RESULTS);
        end
    end

    assign can_write = r_fill < eff_cap;
    assign wr_ok     = i_cmd.take && (act == ACT_WRITE) && can_write;
    assign multi     = ((act == ACT_PEEK) || (act == ACT_READ)) && (run_len != '0);

    // state after the step; equals the current state while streaming
    always_comb begin
        n_head    = r_head;
        n_fill    = r_fill;
        n_written = r_written;
        n_read    = r_read;
        n_ended   = r_ended;
        if (i_cmd.take) begin
            case (act)
                ACT_WRITE: begin
                    if (can_write) begin
                        n_fill    = r_fill + CNT_W'(1);
                        n_written = r_written + TOT_W'(1);
                    end
                end
                ACT_END: begin
                    n_ended = 1'b1;
                end
                ACT_POP, ACT_READ: begin
                    n_head = f_slot(r_head, run_len);
                    n_fill = r_fill - run_len;
                    n_read = r_read + TOT_W'(run_len);
                end
                default: begin
                end
            endcase
        end
    end

    assign room = (n_fill < eff_cap) ? eff_cap - n_fill : '0;

    always_comb begin
        n_res.occupancy     = FCNT_W'(n_fill);
        n_res.room_left     = FCNT_W'(room);
        n_res.total_written = n_written;
        n_res.total_read    = n_read;
        n_res.ended         = n_ended;
        n_res.at_eof        = n_ended && (n_fill == '0);
        if (i_cmd.move) begin
            n_res.out_byte   = ram_rdata;
            n_res.byte_valid = 1'b1;
            n_res.last       = r_left_deliver == CNT_W'(1);
            n_res.accepted   = 1'b0;
        end else begin
            n_res.out_byte   = '0;
            n_res.byte_valid = 1'b0;
            n_res.last       = 1'b1;
            n_res.accepted   = wr_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_fill         <= '0;
            r_written      <= '0;
            r_read         <= '0;
            r_ended        <= 1'b0;
            r_left_issue   <= '0;
            r_left_deliver <= '0;
            r_rd_pend      <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_written <= n_written;
            r_read    <= n_read;
            r_ended   <= n_ended;
            if (i_cmd.take && multi) begin
                r_left_issue   <= run_len;
                r_left_deliver <= run_len;
            end else begin
                if (i_cmd.issue) begin
                    r_left_issue <= r_left_issue - CNT_W'(1);
                end
                if (i_cmd.move) begin
                    r_left_deliver <= r_left_deliver - CNT_W'(1);
                end
            end
            if (i_cmd.issue) begin
                r_rd_pend <= 1'b1;
            end else if (i_cmd.move) begin
                r_rd_pend <= 1'b0;
            end
            if ((i_cmd.take && !multi) || i_cmd.move) begin
                r_res_valid <= 1'b1;
            end else if (i_cmd.drain) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && multi) begin
            r_rd_addr <= r_head;
        end else if (i_cmd.issue) begin
            r_rd_addr <= f_slot(r_rd_addr, CNT_W'(1));
        end
        if ((i_cmd.take && !multi) || i_cmd.move) begin
            r_res <= n_res;
        end
    end

    fbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (f_slot(r_head, r_fill)),
        .i_wdata (i_in_byte),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.multi        = multi;
    assign o_stat.issue_left   = r_left_issue != '0;
    assign o_stat.last_deliver = r_left_deliver == CNT_W'(1);
    assign o_stat.rd_pend      = r_rd_pend;
    assign o_stat.out_busy     = r_res_valid;
    assign o_res_valid         = r_res_valid;
    assign o_res               = r_res;
endmodule

[sv/flow_controlled_byte_fifo.sv]
// Top level of the flow-controlled byte FIFO: capacity register, controller, datapath.
// A write, end, pop or status-only request gives a single status result, and a new request is
// taken every cycle while the result side keeps up; a peek or read of n bytes (n cut to the
// fill level) runs as the request, the registered read of the byte store, then one byte per
// cycle while the result side keeps up, and the next request is taken once the
// last byte has moved into the result register. Every result carries the status after
// its request. The capacity register sits at byte address 0 of the APB port and resets
// to 32; write it only while no request is in flight.
module flow_controlled_byte_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fbf_in_if.sink                       i_in,
    fbf_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbf_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbf_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import fbf_pkg::*;

    logic [FCNT_W-1:0] r_capacity;
    logic [0:0]        reg_idx;
    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic              res_valid;
    t_result           res;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_CAPACITY) ? PDATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY)) begin
            r_capacity <= pwdata[FCNT_W-1:0];
        end
    end

    fbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fbf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_in.action),
        .i_in_byte   (i_in.in_byte),
        .i_req_count (i_in.req_count),
        .i_capacity  (r_capacity),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_out.valid         = res_valid;
    assign o_out.out_byte      = res.out_byte;
    assign o_out.byte_valid    = res.byte_valid;
    assign o_out.last          = res.last;
    assign o_out.accepted      = res.accepted;
    assign o_out.occupancy     = res.occupancy;
    assign o_out.room_left     = res.room_left;
    assign o_out.total_written = res.total_written;
    assign o_out.total_read    = res.total_read;
    assign o_out.ended         = res.ended;
    assign o_out.at_eof        = res.at_eof;
endmodule

[sv/fbf_checker.sv]
// Port-level checks of the byte FIFO, bound to the top level.
module fbf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_byte_valid,
    input logic                        i_last,
    input logic                        i_accepted,
    input logic [fbf_pkg::FCNT_W-1:0]  i_occupancy,
    input logic                        i_ended,
    input logic                        i_at_eof
);
    import fbf_pkg::*;

    // a stored write gives one status result, never a byte
    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> i_last && !i_byte_valid)
        else $error("accepted write result is not a lone status result");

    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_at_eof == (i_ended && (i_occupancy == '0))))
        else $error("at_eof disagrees with ended and occupancy");

    // no new request while a byte run is still being delivered
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("request taken in the middle of a byte run");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");
endmodule

bind flow_controlled_byte_fifo fbf_checker u_fbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_byte_valid (o_out.byte_valid),
    .i_last       (o_out.last),
    .i_accepted   (o_out.accepted),
    .i_occupancy  (o_out.occupancy),
    .i_ended      (o_out.ended),
    .i_at_eof     (o_out.at_eof)
);
